FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge out of reset
`define TLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen out of reset
`define TLT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/tlt_pkg.sv
// types and constants of the tftp lockstep transfer block
// no dependencies; used by all tlt modules by scoped names
`timescale 1ns / 1ps

package tlt_pkg;

    typedef enum logic [2:0] {
        OP_START_RD  = 3'd0,
        OP_START_WR  = 3'd1,
        OP_PACKET    = 3'd2,
        OP_TICK      = 3'd3,
        OP_SEG_READY = 3'd4,
        OP_STORED    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_RFETCH  = 3'd1,
        MODE_RACK    = 3'd2,
        MODE_WDATA   = 3'd3,
        MODE_WSTORE  = 3'd4,
        MODE_WLINGER = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        ACT_NONE  = 4'd0,
        ACT_FETCH = 4'd1,
        ACT_DATA  = 4'd2,
        ACT_ACK   = 4'd3,
        ACT_ERR   = 4'd4,
        ACT_STORE = 4'd5,
        ACT_DRAIN = 4'd6,
        ACT_DONE  = 4'd7,
        ACT_ABORT = 4'd8
    } act_t;

    localparam logic [15:0] PKT_DATA  = 16'd3;
    localparam logic [15:0] PKT_ACK   = 16'd4;
    localparam logic [15:0] PKT_ERROR = 16'd5;

    localparam logic ERR_UNDEF     = 1'b0;
    localparam logic ERR_DISK_FULL = 1'b1;

    // register index as decoded from paddr[2]
    localparam logic REG_INTERVAL = 1'b0;
    localparam logic REG_MAX_WAIT = 1'b1;

    localparam logic [7:0]  CFG_INTERVAL_RST = 8'd5;
    localparam logic [15:0] CFG_MAX_WAIT_RST = 16'd25;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        act_t        action;
        logic [15:0] blk;
        logic [9:0]  len;
        logic        err;
        logic        hint;
    } res_t;

    // one queue entry holds every result of one input beat
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } q_entry_t;

    typedef struct packed {
        logic [7:0]  interval;
        logic [15:0] max_wait;
    } cfg_t;

endpackage

FILE: hw/rtl/tlt_queue.sv
// result queue between front and back of the tftp transfer block
// depends on tlt_pkg
`timescale 1ns / 1ps

module tlt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tlt_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output tlt_pkg::q_entry_t  head,
    output logic               full,
    output logic               empty
);

    tlt_pkg::q_entry_t                 mem [tlt_pkg::QDEPTH];
    logic [tlt_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tlt_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tlt_pkg::QCNT_W-1:0]        count_reg;
    logic [tlt_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [tlt_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [tlt_pkg::QCNT_W-1:0]        count_next;

    assign full  = count_reg == tlt_pkg::QCNT_W'(tlt_pkg::QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/tlt_front.sv
// front of the tftp transfer block: takes event beats, keeps transfer state,
// and queues the results of each beat; depends on tlt_pkg
`timescale 1ns / 1ps

module tlt_front #(
    parameter int SEG_BYTES = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlt_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic [15:0]        pkt_opcode,
    input  logic [15:0]        pkt_block,
    input  logic [9:0]         seg_length,
    input  logic               io_failed,
    input  logic               store_short,
    input  logic               q_full,
    output logic               push,
    output tlt_pkg::q_entry_t  push_entry
);

    localparam logic [10:0] SEG_LEN   = 11'(SEG_BYTES);
    localparam logic [9:0]  SEG_CLAMP = 10'(SEG_BYTES);

    tlt_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    block_reg, block_next;
    logic [9:0]     len_reg, len_next;
    logic [7:0]     tick_reg, tick_next;
    logic [15:0]    total_reg, total_next;
    logic           conf_reg, conf_next;

    logic           accept;
    logic [15:0]    blk_prev;
    logic           blk_cur_hit;
    logic           blk_prev_hit;
    logic [9:0]     len_clamped;
    logic           len_full;
    logic [7:0]     iv;
    logic [7:0]     tick_inc;
    logic           tick_hit;
    logic [16:0]    wait_sum;
    logic           wait_over;
    logic           timer_on;
    logic           has_res;
    tlt_pkg::res_t  r0;
    tlt_pkg::res_t  r1;
    logic           two;

    function automatic tlt_pkg::res_t mk_res(input tlt_pkg::act_t act,
                                             input logic [15:0] blk,
                                             input logic [9:0] len,
                                             input logic err,
                                             input logic hint);
        tlt_pkg::res_t r;
        r.action = act;
        r.blk    = blk;
        r.len    = len;
        r.err    = err;
        r.hint   = hint;
        return r;
    endfunction

    assign in_ready     = !q_full;
    assign accept       = in_valid && in_ready;
    assign blk_prev     = block_reg - 16'd1;
    assign blk_cur_hit  = pkt_block == block_reg;
    assign blk_prev_hit = pkt_block == blk_prev;
    assign len_clamped  = ({1'b0, seg_length} > SEG_LEN) ? SEG_CLAMP : seg_length;
    assign len_full     = {1'b0, len_reg} == SEG_LEN;
    // zero interval behaves as one tick
    assign iv           = (cfg.interval == 8'd0) ? 8'd1 : cfg.interval;
    assign tick_inc     = tick_reg + 8'd1;
    assign tick_hit     = tick_inc >= iv;
    assign wait_sum     = {1'b0, total_reg} + {9'd0, iv};
    assign wait_over    = wait_sum >= {1'b0, cfg.max_wait};
    assign timer_on     = mode_reg inside {tlt_pkg::MODE_RACK, tlt_pkg::MODE_WDATA,
                                           tlt_pkg::MODE_WLINGER};

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        block_next = block_reg;
        len_next   = len_reg;
        tick_next  = tick_reg;
        total_next = total_reg;
        conf_next  = conf_reg;
        if (accept)
        begin
            case (op)
                tlt_pkg::OP_START_RD, tlt_pkg::OP_START_WR:
                begin
                    conf_next  = 1'b0;
                    tick_next  = '0;
                    total_next = '0;
                    len_next   = '0;
                    block_next = 16'd1;
                    if (op == tlt_pkg::OP_START_RD)
                    begin
                        mode_next = tlt_pkg::MODE_RFETCH;
                    end
                    else
                    begin
                        mode_next = tlt_pkg::MODE_WDATA;
                    end
                end
                tlt_pkg::OP_PACKET:
                begin
                    if (mode_reg == tlt_pkg::MODE_WLINGER)
                    begin
                        mode_next = tlt_pkg::MODE_IDLE;
                    end
                    else if (mode_reg == tlt_pkg::MODE_RACK ||
                             mode_reg == tlt_pkg::MODE_WDATA)
                    begin
                        tick_next = '0;
                        if (pkt_opcode == tlt_pkg::PKT_ERROR)
                        begin
                            mode_next = tlt_pkg::MODE_IDLE;
                        end
                        else if (mode_reg == tlt_pkg::MODE_RACK &&
                                 pkt_opcode == tlt_pkg::PKT_ACK)
                        begin
                            if (blk_cur_hit)
                            begin
                                conf_next = 1'b1;
                                if (len_full)
                                begin
                                    block_next = block_reg + 16'd1;
                                    mode_next  = tlt_pkg::MODE_RFETCH;
                                end
                                else
                                begin
                                    mode_next = tlt_pkg::MODE_IDLE;
                                end
                            end
                            else if (blk_prev_hit)
                            begin
                                conf_next = 1'b0;
                            end
                        end
                        else if (mode_reg == tlt_pkg::MODE_WDATA &&
                                 pkt_opcode == tlt_pkg::PKT_DATA)
                        begin
                            if (blk_cur_hit)
                            begin
                                conf_next = 1'b1;
                                len_next  = len_clamped;
                                mode_next = tlt_pkg::MODE_WSTORE;
                            end
                            else if (blk_prev_hit)
                            begin
                                conf_next = 1'b0;
                            end
                        end
                    end
                end
                tlt_pkg::OP_TICK:
                begin
                    if (timer_on)
                    begin
                        if (!tick_hit)
                        begin
                            tick_next = tick_inc;
                        end
                        else
                        begin
                            tick_next = '0;
                            if (mode_reg == tlt_pkg::MODE_WLINGER)
                            begin
                                mode_next = tlt_pkg::MODE_IDLE;
                            end
                            else
                            begin
                                conf_next  = 1'b0;
                                total_next = wait_sum[15:0];
                                if (wait_over)
                                begin
                                    mode_next = tlt_pkg::MODE_IDLE;
                                end
                            end
                        end
                    end
                end
                tlt_pkg::OP_SEG_READY:
                begin
                    if (mode_reg == tlt_pkg::MODE_RFETCH)
                    begin
                        if (io_failed)
                        begin
                            mode_next = tlt_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            len_next   = len_clamped;
                            total_next = '0;
                            mode_next  = tlt_pkg::MODE_RACK;
                            conf_next  = 1'b0;
                            tick_next  = '0;
                        end
                    end
                end
                tlt_pkg::OP_STORED:
                begin
                    if (mode_reg == tlt_pkg::MODE_WSTORE)
                    begin
                        if (io_failed || store_short)
                        begin
                            mode_next = tlt_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            total_next = '0;
                            tick_next  = '0;
                            if (len_full)
                            begin
                                conf_next  = 1'b0;
                                block_next = block_reg + 16'd1;
                                mode_next  = tlt_pkg::MODE_WDATA;
                            end
                            else
                            begin
                                mode_next = tlt_pkg::MODE_WLINGER;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // results of the current beat
    always_comb
    begin
        has_res = 1'b0;
        two     = 1'b0;
        r0      = mk_res(tlt_pkg::ACT_NONE, '0, '0, 1'b0, 1'b0);
        r1      = mk_res(tlt_pkg::ACT_NONE, '0, '0, 1'b0, 1'b0);
        case (op)
            tlt_pkg::OP_START_RD:
            begin
                has_res = 1'b1;
                r0      = mk_res(tlt_pkg::ACT_FETCH, 16'd1, '0, 1'b0, 1'b0);
            end
            tlt_pkg::OP_START_WR:
            begin
                has_res = 1'b1;
                r0      = mk_res(tlt_pkg::ACT_ACK, '0, '0, 1'b0, 1'b0);
            end
            tlt_pkg::OP_PACKET:
            begin
                if (mode_reg == tlt_pkg::MODE_WLINGER)
                begin
                    has_res = 1'b1;
                    // duplicate final block gets the last ack again
                    if (pkt_opcode == tlt_pkg::PKT_DATA && blk_cur_hit)
                    begin
                        two = 1'b1;
                        r0  = mk_res(tlt_pkg::ACT_ACK, block_reg, '0, 1'b0, 1'b0);
                        r1  = mk_res(tlt_pkg::ACT_DONE, '0, '0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        r0 = mk_res(tlt_pkg::ACT_DONE, '0, '0, 1'b0, 1'b0);
                    end
                end
                else if (mode_reg == tlt_pkg::MODE_RACK ||
                         mode_reg == tlt_pkg::MODE_WDATA)
                begin
                    if (pkt_opcode == tlt_pkg::PKT_ERROR)
                    begin
                        has_res = 1'b1;
                        r0      = mk_res(tlt_pkg::ACT_ABORT, '0, '0, 1'b0, 1'b0);
                    end
                    else if (mode_reg == tlt_pkg::MODE_RACK &&
                             pkt_opcode == tlt_pkg::PKT_ACK)
                    begin
                        has_res = 1'b1;
                        if (blk_cur_hit)
                        begin
                            if (len_full)
                            begin
                                r0 = mk_res(tlt_pkg::ACT_FETCH, block_reg + 16'd1, '0,
                                            1'b0, 1'b0);
                            end
                            else
                            begin
                                r0 = mk_res(tlt_pkg::ACT_DONE, '0, '0, 1'b0, 1'b0);
                            end
                        end
                        else
                        begin
                            r0 = mk_res(tlt_pkg::ACT_DRAIN, '0, '0, 1'b0, 1'b0);
                            if (blk_prev_hit)
                            begin
                                two = 1'b1;
                                r1  = mk_res(tlt_pkg::ACT_DATA, block_reg, len_reg,
                                             1'b0, conf_reg);
                            end
                        end
                    end
                    else if (mode_reg == tlt_pkg::MODE_WDATA &&
                             pkt_opcode == tlt_pkg::PKT_DATA)
                    begin
                        has_res = 1'b1;
                        if (blk_cur_hit)
                        begin
                            r0 = mk_res(tlt_pkg::ACT_STORE, block_reg, len_clamped,
                                        1'b0, 1'b0);
                        end
                        else
                        begin
                            r0 = mk_res(tlt_pkg::ACT_DRAIN, '0, '0, 1'b0, 1'b0);
                            if (blk_prev_hit)
                            begin
                                two = 1'b1;
                                r1  = mk_res(tlt_pkg::ACT_ACK, blk_prev, '0, 1'b0,
                                             conf_reg);
                            end
                        end
                    end
                end
            end
            tlt_pkg::OP_TICK:
            begin
                if (timer_on && tick_hit)
                begin
                    has_res = 1'b1;
                    if (mode_reg == tlt_pkg::MODE_WLINGER)
                    begin
                        r0 = mk_res(tlt_pkg::ACT_DONE, '0, '0, 1'b0, 1'b0);
                    end
                    else if (wait_over)
                    begin
                        r0 = mk_res(tlt_pkg::ACT_ABORT, '0, '0, 1'b0, 1'b0);
                    end
                    else if (mode_reg == tlt_pkg::MODE_RACK)
                    begin
                        r0 = mk_res(tlt_pkg::ACT_DATA, block_reg, len_reg, 1'b0, 1'b0);
                    end
                    else
                    begin
                        r0 = mk_res(tlt_pkg::ACT_ACK, blk_prev, '0, 1'b0, 1'b0);
                    end
                end
            end
            tlt_pkg::OP_SEG_READY:
            begin
                if (mode_reg == tlt_pkg::MODE_RFETCH)
                begin
                    has_res = 1'b1;
                    if (io_failed)
                    begin
                        two = 1'b1;
                        r0  = mk_res(tlt_pkg::ACT_ERR, '0, '0, tlt_pkg::ERR_UNDEF, 1'b0);
                        r1  = mk_res(tlt_pkg::ACT_ABORT, '0, '0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        r0 = mk_res(tlt_pkg::ACT_DATA, block_reg, len_clamped, 1'b0,
                                    conf_reg);
                    end
                end
            end
            tlt_pkg::OP_STORED:
            begin
                if (mode_reg == tlt_pkg::MODE_WSTORE)
                begin
                    has_res = 1'b1;
                    if (io_failed || store_short)
                    begin
                        two = 1'b1;
                        r0  = mk_res(tlt_pkg::ACT_ERR, '0, '0,
                                     io_failed ? tlt_pkg::ERR_UNDEF
                                               : tlt_pkg::ERR_DISK_FULL, 1'b0);
                        r1  = mk_res(tlt_pkg::ACT_ABORT, '0, '0, 1'b0, 1'b0);
                    end
                    else
                    begin
                        r0 = mk_res(tlt_pkg::ACT_ACK, block_reg, '0, 1'b0, conf_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push          = accept && has_res;
    assign push_entry.two = two;
    assign push_entry.r0  = r0;
    assign push_entry.r1  = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= tlt_pkg::MODE_IDLE;
            block_reg <= '0;
            len_reg   <= '0;
            tick_reg  <= '0;
            total_reg <= '0;
            conf_reg  <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            block_reg <= block_next;
            len_reg   <= len_next;
            tick_reg  <= tick_next;
            total_reg <= total_next;
            conf_reg  <= conf_next;
        end
    end

endmodule

FILE: hw/rtl/tlt_back.sv
// back of the tftp transfer block: unpacks queued entries into result beats
// through an output register; depends on tlt_pkg
`timescale 1ns / 1ps

module tlt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tlt_pkg::q_entry_t  head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output tlt_pkg::res_t      out_res,
    output logic               out_last
);

    logic           valid_reg, valid_next;
    logic           phase_reg, phase_next;
    tlt_pkg::res_t  res_reg;
    logic           last_reg;
    logic           load;
    logic           take;
    logic           end_of_entry;

    // output register frees up when empty or when its beat is taken
    assign load         = !valid_reg || out_ready;
    assign take         = load && !empty;
    assign end_of_entry = phase_reg || !head.two;
    assign pop          = take && end_of_entry;

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (load)
        begin
            valid_next = !empty;
        end
        if (take)
        begin
            phase_next = !end_of_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg  <= phase_reg ? head.r1 : head.r0;
            last_reg <= end_of_entry;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

FILE: hw/rtl/tftp_lockstep_transfer.sv
// top level of the tftp lockstep transfer block with its apb register port
// depends on tlt_pkg, tlt_front, tlt_queue, tlt_back
//
//  channel   signals                                    beat
//  --------  -----------------------------------------  ----------------------
//  in        in_valid/in_ready, op .. store_short       one event
//  out       out_valid/out_ready, action .. last        one result
//  config    psel/penable/pwrite/paddr/pwdata/prdata    one register write/read
//
//  one event beat per cycle while the four-entry result queue has room
//  results leave one per cycle while out_ready is high; an event with two results gives two output beats
//  first result is registered in its queue entry, then in the output register, before it is valid
//  reset clears mode, counters, queue and output valid; registers return to 5 and 25
//  a stalled output fills the queue, then in_ready drops
`timescale 1ns / 1ps

module tftp_lockstep_transfer #(
    parameter int SEG_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] pkt_opcode,
    input  logic [15:0] pkt_block,
    input  logic [9:0]  seg_length,
    input  logic        io_failed,
    input  logic        store_short,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [15:0] out_block,
    output logic [9:0]  out_length,
    output logic        err_kind,
    output logic        confirm_hint,
    output logic        last
);

    logic [7:0]         interval_reg, interval_next;
    logic [15:0]        max_wait_reg, max_wait_next;
    logic               cfg_wr;
    tlt_pkg::cfg_t      cfg;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    tlt_pkg::q_entry_t  q_in;
    tlt_pkg::q_entry_t  q_head;
    tlt_pkg::res_t      res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        interval_next = interval_reg;
        max_wait_next = max_wait_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                tlt_pkg::REG_INTERVAL: interval_next = pwdata[7:0];
                tlt_pkg::REG_MAX_WAIT: max_wait_next = pwdata[15:0];
                default:               interval_next = interval_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            tlt_pkg::REG_INTERVAL: prdata = {24'd0, interval_reg};
            tlt_pkg::REG_MAX_WAIT: prdata = {16'd0, max_wait_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= tlt_pkg::CFG_INTERVAL_RST;
            max_wait_reg <= tlt_pkg::CFG_MAX_WAIT_RST;
        end
        else
        begin
            interval_reg <= interval_next;
            max_wait_reg <= max_wait_next;
        end
    end

    assign cfg.interval = interval_reg;
    assign cfg.max_wait = max_wait_reg;

    tlt_front #(
        .SEG_BYTES (SEG_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .pkt_opcode  (pkt_opcode),
        .pkt_block   (pkt_block),
        .seg_length  (seg_length),
        .io_failed   (io_failed),
        .store_short (store_short),
        .q_full      (q_full),
        .push        (q_push),
        .push_entry  (q_in)
    );

    tlt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    tlt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res),
        .out_last  (last)
    );

    assign action       = res.action;
    assign out_block    = res.blk;
    assign out_length   = res.len;
    assign err_kind     = res.err;
    assign confirm_hint = res.hint;

endmodule

FILE: hw/rtl/tlt_checker.sv
// port-level checks for the tftp lockstep transfer block, bound to the top level
// depends on tlt_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  action,
    input logic [15:0] out_block,
    input logic [9:0]  out_length,
    input logic        confirm_hint,
    input logic        last,
    input logic        pready
);

    // a stalled result beat keeps its payload
    `TLT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(action) && $stable(out_block) && $stable(out_length) && $stable(last), "stalled result changed")

    `TLT_NEVER(a_act_code, clk, rst_n, out_valid && (action == tlt_pkg::ACT_NONE || action > tlt_pkg::ACT_ABORT), "result with no action")

    // drain, done and abort carry no block, length or hint
    `TLT_ASSERT(a_ctl_zero, clk, rst_n, out_valid && (action == tlt_pkg::ACT_DRAIN || action == tlt_pkg::ACT_DONE || action == tlt_pkg::ACT_ABORT) |-> out_block == 16'd0 && out_length == 10'd0 && !confirm_hint, "control result with payload")

    // a transfer ending closes the event's results
    `TLT_ASSERT(a_end_last, clk, rst_n, out_valid && (action == tlt_pkg::ACT_DONE || action == tlt_pkg::ACT_ABORT) |-> last, "done or abort not marked last")

    `TLT_NEVER(a_pready, clk, rst_n, !pready, "register port stalled")

endmodule

bind tftp_lockstep_transfer tlt_checker u_tlt_checker (.*);

FILE: sim/tftp_lockstep_transfer_test.sv
// self-checking testbench for the tftp lockstep transfer block
// depends on tlt_pkg and tftp_lockstep_transfer; a tracker class predicts every action
// directed transfers first, then random transfers with some noise under several register settings
`timescale 1ns / 1ps

module tftp_lockstep_transfer_test;

    localparam int SEG_BYTES     = 512;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BEATS   = 270;
    localparam int PHASES        = 6;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] opcode;
        logic [15:0] blk;
        logic [9:0]  len;
        logic        fail;
        logic        shortw;
    } tlt_event_t;

    typedef struct packed {
        tlt_pkg::act_t action;
        logic [15:0]   blk;
        logic [9:0]    len;
        logic          err;
        logic          hint;
        logic          last;
    } tlt_result_t;

    // tracks the transfer state and the actions still owed by the block
    class tftp_action_tracker;
        logic [7:0]     interval;
        logic [15:0]    max_wait;
        tlt_pkg::mode_t mode;
        logic [15:0]    block_no;
        logic [9:0]     cur_len;
        int             ticks;
        int             total_wait;
        logic           confirmed;
        tlt_result_t    due_actions[$];
        tlt_result_t    fresh[$];
        int             failures;

        function new();
            interval   = tlt_pkg::CFG_INTERVAL_RST;
            max_wait   = tlt_pkg::CFG_MAX_WAIT_RST;
            mode       = tlt_pkg::MODE_IDLE;
            block_no   = 16'd0;
            cur_len    = 10'd0;
            ticks      = 0;
            total_wait = 0;
            confirmed  = 1'b0;
            failures   = 0;
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == tlt_pkg::REG_INTERVAL)
                interval = value[7:0];
            else
                max_wait = value[15:0];
        endfunction

        function void push(tlt_pkg::act_t a, logic [15:0] b, logic [9:0] l, logic e,
                           logic h);
            tlt_result_t r;
            r.action = a;
            r.blk    = b;
            r.len    = l;
            r.err    = e;
            r.hint   = h;
            r.last   = 1'b0;
            fresh.push_back(r);
        endfunction

        function logic [9:0] clamp_length(logic [9:0] v);
            return (v > SEG_BYTES) ? 10'(SEG_BYTES) : v;
        endfunction

        function void owe_data();
            push(tlt_pkg::ACT_DATA, block_no, cur_len, tlt_pkg::ERR_UNDEF, confirmed);
            confirmed = 1'b0;
            ticks     = 0;
        endfunction

        function void owe_ack(logic [15:0] b);
            push(tlt_pkg::ACT_ACK, b, 10'd0, tlt_pkg::ERR_UNDEF, confirmed);
            confirmed = 1'b0;
            ticks     = 0;
        endfunction

        function void close_transfer(tlt_pkg::act_t a);
            push(a, 16'd0, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
            mode = tlt_pkg::MODE_IDLE;
        endfunction

        // takes one accepted beat, queues its actions, returns how many
        function int apply_event(tlt_event_t ev);
            int          iv;
            logic [15:0] prev;
            tlt_result_t r;
            fresh.delete();
            iv   = (interval == 8'd0) ? 1 : int'(interval);
            prev = block_no - 16'd1;
            case (ev.op)
                tlt_pkg::OP_START_RD, tlt_pkg::OP_START_WR:
                begin
                    confirmed  = 1'b0;
                    ticks      = 0;
                    total_wait = 0;
                    cur_len    = 10'd0;
                    block_no   = 16'd1;
                    if (ev.op == tlt_pkg::OP_START_RD)
                    begin
                        mode = tlt_pkg::MODE_RFETCH;
                        push(tlt_pkg::ACT_FETCH, block_no, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
                    end
                    else
                    begin
                        mode = tlt_pkg::MODE_WDATA;
                        owe_ack(16'd0);
                    end
                end
                tlt_pkg::OP_PACKET:
                begin
                    if (mode == tlt_pkg::MODE_WLINGER)
                    begin
                        // duplicate of the final block gets its ack again
                        if (ev.opcode == tlt_pkg::PKT_DATA && ev.blk == block_no)
                            push(tlt_pkg::ACT_ACK, block_no, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
                        close_transfer(tlt_pkg::ACT_DONE);
                    end
                    else if (mode == tlt_pkg::MODE_RACK || mode == tlt_pkg::MODE_WDATA)
                    begin
                        ticks = 0;
                        if (ev.opcode == tlt_pkg::PKT_ERROR)
                            close_transfer(tlt_pkg::ACT_ABORT);
                        else if (mode == tlt_pkg::MODE_RACK && ev.opcode == tlt_pkg::PKT_ACK)
                        begin
                            if (ev.blk == block_no)
                            begin
                                confirmed = 1'b1;
                                if (cur_len == SEG_BYTES)
                                begin
                                    block_no = block_no + 16'd1;
                                    mode     = tlt_pkg::MODE_RFETCH;
                                    push(tlt_pkg::ACT_FETCH, block_no, 10'd0,
                                         tlt_pkg::ERR_UNDEF, 1'b0);
                                end
                                else
                                    close_transfer(tlt_pkg::ACT_DONE);
                            end
                            else
                            begin
                                push(tlt_pkg::ACT_DRAIN, 16'd0, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
                                if (ev.blk == prev)
                                    owe_data();
                            end
                        end
                        else if (mode == tlt_pkg::MODE_WDATA && ev.opcode == tlt_pkg::PKT_DATA)
                        begin
                            if (ev.blk == block_no)
                            begin
                                confirmed = 1'b1;
                                cur_len   = clamp_length(ev.len);
                                mode      = tlt_pkg::MODE_WSTORE;
                                push(tlt_pkg::ACT_STORE, block_no, cur_len,
                                     tlt_pkg::ERR_UNDEF, 1'b0);
                            end
                            else
                            begin
                                push(tlt_pkg::ACT_DRAIN, 16'd0, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
                                if (ev.blk == prev)
                                    owe_ack(prev);
                            end
                        end
                    end
                end
                tlt_pkg::OP_TICK:
                begin
                    if (mode == tlt_pkg::MODE_RACK || mode == tlt_pkg::MODE_WDATA ||
                        mode == tlt_pkg::MODE_WLINGER)
                    begin
                        ticks++;
                        if (ticks >= iv)
                        begin
                            ticks = 0;
                            if (mode == tlt_pkg::MODE_WLINGER)
                                close_transfer(tlt_pkg::ACT_DONE);
                            else
                            begin
                                confirmed  = 1'b0;
                                total_wait = total_wait + iv;
                                if (total_wait >= int'(max_wait))
                                begin
                                    total_wait = total_wait & 16'hFFFF;
                                    close_transfer(tlt_pkg::ACT_ABORT);
                                end
                                else if (mode == tlt_pkg::MODE_RACK)
                                    owe_data();
                                else
                                    owe_ack(prev);
                            end
                        end
                    end
                end
                tlt_pkg::OP_SEG_READY:
                begin
                    if (mode == tlt_pkg::MODE_RFETCH)
                    begin
                        if (ev.fail)
                        begin
                            push(tlt_pkg::ACT_ERR, 16'd0, 10'd0, tlt_pkg::ERR_UNDEF, 1'b0);
                            close_transfer(tlt_pkg::ACT_ABORT);
                        end
                        else
                        begin
                            cur_len    = clamp_length(ev.len);
                            total_wait = 0;
                            mode       = tlt_pkg::MODE_RACK;
                            owe_data();
                        end
                    end
                end
                tlt_pkg::OP_STORED:
                begin
                    if (mode == tlt_pkg::MODE_WSTORE)
                    begin
                        if (ev.fail || ev.shortw)
                        begin
                            push(tlt_pkg::ACT_ERR, 16'd0, 10'd0,
                                 ev.fail ? tlt_pkg::ERR_UNDEF : tlt_pkg::ERR_DISK_FULL, 1'b0);
                            close_transfer(tlt_pkg::ACT_ABORT);
                        end
                        else
                        begin
                            total_wait = 0;
                            if (cur_len == SEG_BYTES)
                            begin
                                owe_ack(block_no);
                                block_no = block_no + 16'd1;
                                mode     = tlt_pkg::MODE_WDATA;
                            end
                            else
                            begin
                                // final ack keeps the confirm flag
                                push(tlt_pkg::ACT_ACK, block_no, 10'd0, tlt_pkg::ERR_UNDEF,
                                     confirmed);
                                ticks = 0;
                                mode  = tlt_pkg::MODE_WLINGER;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (fresh.size() > 0)
            begin
                r = fresh.pop_back();
                r.last = 1'b1;
                fresh.push_back(r);
            end
            foreach (fresh[i])
                due_actions.push_back(fresh[i]);
            return fresh.size();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_action(logic [3:0] act, logic [15:0] blk, logic [9:0] len,
                                   logic err, logic hint, logic fin);
            tlt_result_t want;
            if (due_actions.size() == 0)
            begin
                $error("unexpected result beat: action %0d block %0d", act, blk);
                failures++;
                return;
            end
            want = due_actions.pop_front();
            compare_field("action", 16'(want.action), 16'(act));
            compare_field("out_block", want.blk, blk);
            compare_field("out_length", 16'(want.len), 16'(len));
            compare_field("err_kind", 16'(want.err), 16'(err));
            compare_field("confirm_hint", 16'(want.hint), 16'(hint));
            compare_field("last", 16'(want.last), 16'(fin));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = 3'd0;
    logic [15:0] pkt_opcode = 16'd0;
    logic [15:0] pkt_block = 16'd0;
    logic [9:0]  seg_length = 10'd0;
    logic        io_failed = 1'b0;
    logic        store_short = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  action;
    logic [15:0] out_block;
    logic [9:0]  out_length;
    logic        err_kind;
    logic        confirm_hint;
    logic        last;

    tftp_action_tracker tracker = new();
    int cycle_count = 0;
    int tick_pct = 20;

    tftp_lockstep_transfer dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_action(action, out_block, out_length, err_kind, confirm_hint, last);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: picks a random stall style, with a long hold now and then
    initial
    begin
        int rx_cycle;
        int style;
        rx_cycle = 0;
        style    = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle % 4000 == 400)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                rx_cycle += 300;
            end
            if (rx_cycle % 64 == 0)
                style = $urandom_range(0, 3);
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ~out_ready;
            endcase
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // holds the beat until accepted, then hands it to the tracker
    task automatic offer(input tlt_event_t ev, output int n);
        in_valid    <= 1'b1;
        op          <= ev.op;
        pkt_opcode  <= ev.opcode;
        pkt_block   <= ev.blk;
        seg_length  <= ev.len;
        io_failed   <= ev.fail;
        store_short <= ev.shortw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n = tracker.apply_event(ev);
    endtask

    task automatic wait_idle();
        while (tracker.due_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic tlt_event_t mk_event(logic [2:0] o, logic [15:0] opc, logic [15:0] b,
                                            logic [9:0] l, logic f, logic s);
        tlt_event_t ev;
        ev.op     = o;
        ev.opcode = opc;
        ev.blk    = b;
        ev.len    = l;
        ev.fail   = f;
        ev.shortw = s;
        return ev;
    endfunction

    // mostly full segments so transfers run several blocks
    function automatic logic [9:0] segment_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return 10'(SEG_BYTES);
        else if (roll < 85)
            return 10'($urandom_range(SEG_BYTES + 1, 1023));
        return 10'($urandom_range(0, SEG_BYTES - 1));
    endfunction

    // picks a beat that fits the current transfer state, with some noise
    function automatic tlt_event_t next_event();
        tlt_event_t  ev;
        int          roll;
        int          pick;
        logic [15:0] prev;
        ev.op     = tlt_pkg::OP_TICK;
        ev.opcode = 16'($urandom_range(0, 65535));
        ev.blk    = 16'($urandom_range(0, 65535));
        ev.len    = 10'($urandom_range(0, 1023));
        ev.fail   = 1'b0;
        ev.shortw = 1'b0;
        prev      = tracker.block_no - 16'd1;
        if ($urandom_range(0, 99) < 3)
        begin
            ev.op     = 3'($urandom_range(0, 7));
            ev.fail   = 1'($urandom_range(0, 1));
            ev.shortw = 1'($urandom_range(0, 1));
            return ev;
        end
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        case (tracker.mode)
            tlt_pkg::MODE_IDLE:
                ev.op = (roll < 50) ? tlt_pkg::OP_START_RD : tlt_pkg::OP_START_WR;
            tlt_pkg::MODE_RFETCH:
            begin
                ev.op   = tlt_pkg::OP_SEG_READY;
                ev.fail = (roll < 3);
                ev.len  = segment_length();
            end
            tlt_pkg::MODE_RACK, tlt_pkg::MODE_WDATA:
            begin
                if (roll >= tick_pct)
                begin
                    ev.op     = tlt_pkg::OP_PACKET;
                    ev.opcode = (tracker.mode == tlt_pkg::MODE_RACK) ? tlt_pkg::PKT_ACK
                                                                     : tlt_pkg::PKT_DATA;
                    ev.len    = segment_length();
                    if (pick < 70)
                        ev.blk = tracker.block_no;
                    else if (pick < 80)
                        ev.blk = prev;
                    else if (pick < 90)
                        ev.opcode = tlt_pkg::PKT_ERROR;
                    else if (pick < 96)
                        ev.opcode = 16'($urandom_range(0, 65535));
                    else
                        ev.op = (pick < 98) ? tlt_pkg::OP_START_RD : tlt_pkg::OP_START_WR;
                end
            end
            tlt_pkg::MODE_WSTORE:
            begin
                ev.op = tlt_pkg::OP_STORED;
                if (roll < 3)
                begin
                    ev.fail   = 1'b1;
                    ev.shortw = 1'($urandom_range(0, 1));
                end
                else if (roll < 6)
                    ev.shortw = 1'b1;
            end
            tlt_pkg::MODE_WLINGER:
            begin
                if (roll >= tick_pct + 20)
                begin
                    ev.op = tlt_pkg::OP_PACKET;
                    if (pick < 60)
                    begin
                        ev.opcode = tlt_pkg::PKT_DATA;
                        ev.blk    = tracker.block_no;
                    end
                end
            end
            default: ;
        endcase
        return ev;
    endfunction

    initial
    begin
        tlt_event_t  plan[$];
        tlt_event_t  ev;
        int          n;
        int          busy_beats;
        int          burst;
        int          gap;
        logic [7:0]  iv_cfg;
        logic [15:0] max_cfg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero interval behaves as one; limit of two timeouts
        apb_write(tlt_pkg::REG_INTERVAL, 32'd0);
        apb_write(tlt_pkg::REG_MAX_WAIT, 32'd2);
        plan.push_back(mk_event(OP_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1, 1'b1));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_ACK, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_START_RD, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_ACK, 16'd1, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_SEG_READY, 16'd0, 16'd0, 10'h3FF, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_ACK, 16'h8000, 10'd0, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_ACK, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, 16'hFFFF, 16'd1, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_TICK, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_TICK, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_START_WR, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_DATA, 16'd1, 10'd512, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_STORED, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_DATA, 16'd1, 10'd512, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_DATA, 16'd2, 10'd0, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_STORED, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_DATA, 16'd2, 10'd0, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_START_WR, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_DATA, 16'd1, 10'd7, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_STORED, 16'd0, 16'd0, 10'd0, 1'b0, 1'b1));
        plan.push_back(mk_event(tlt_pkg::OP_START_RD, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_START_WR, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_PACKET, tlt_pkg::PKT_ERROR, 16'd1, 10'd0, 1'b0,
                                1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_START_RD, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0));
        plan.push_back(mk_event(tlt_pkg::OP_SEG_READY, 16'd0, 16'd0, 10'd0, 1'b1, 1'b0));
        foreach (plan[i])
            offer(plan[i], n);
        in_valid <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    iv_cfg   = 8'd5;
                    max_cfg  = 16'd25;
                    tick_pct = 20;
                end
                1:
                begin
                    iv_cfg   = 8'd1;
                    max_cfg  = 16'd1;
                    tick_pct = 15;
                end
                2:
                begin
                    iv_cfg   = 8'd0;
                    max_cfg  = 16'd3;
                    tick_pct = 25;
                end
                3:
                begin
                    iv_cfg   = 8'd255;
                    max_cfg  = 16'd65535;
                    tick_pct = 10;
                end
                4:
                begin
                    iv_cfg   = 8'd2;
                    max_cfg  = 16'd9;
                    tick_pct = 40;
                end
                default:
                begin
                    iv_cfg   = 8'($urandom_range(1, 4));
                    max_cfg  = 16'($urandom_range(2, 40));
                    tick_pct = 30;
                end
            endcase
            apb_write(tlt_pkg::REG_INTERVAL, 32'(iv_cfg));
            apb_write(tlt_pkg::REG_MAX_WAIT, 32'(max_cfg));

            busy_beats = 0;
            while (busy_beats < PHASE_BEATS)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst)
                begin
                    ev = next_event();
                    offer(ev, n);
                    if (n > 0)
                        busy_beats++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        if (tracker.failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tlt_pkg.sv
hw/rtl/tlt_queue.sv
hw/rtl/tlt_front.sv
hw/rtl/tlt_back.sv
hw/rtl/tftp_lockstep_transfer.sv
hw/rtl/tlt_checker.sv
sim/tftp_lockstep_transfer_test.sv
